// ----- design/versatile_interface_adapter_defines.svh -----
// ----------------------------------------------------------------------------
// Versatile interface adapter assertion macros
// Concurrent assertion wrappers shared by the adapter RTL files.
// ----------------------------------------------------------------------------
`ifndef VERSATILE_INTERFACE_ADAPTER_DEFINES_SVH
`define VERSATILE_INTERFACE_ADAPTER_DEFINES_SVH

`ifndef ASSERT_OFF

// clocked assertion, disabled while reset is high
`define VIA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define VIA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define VIA_ASSERT(lbl, clk, rst, prop, msg)
`define VIA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- design/via_pkg.sv -----
// ----------------------------------------------------------------------------
// via_pkg
// Types and codes shared by the versatile interface adapter modules.
// ----------------------------------------------------------------------------
package via_pkg;

   // transaction function codes
   localparam logic [2:0] FUNC_READ  = 3'd0;
   localparam logic [2:0] FUNC_WRITE = 3'd1;
   localparam logic [2:0] FUNC_TICK  = 3'd2;
   localparam logic [2:0] FUNC_PIN_A = 3'd3;
   localparam logic [2:0] FUNC_PIN_B = 3'd4;

   // register map
   localparam logic [3:0] REG_PORTB    = 4'd0;
   localparam logic [3:0] REG_PORTA    = 4'd1;
   localparam logic [3:0] REG_DIRB     = 4'd2;
   localparam logic [3:0] REG_DIRA     = 4'd3;
   localparam logic [3:0] REG_T1_LOW   = 4'd4;
   localparam logic [3:0] REG_T1_HIGH  = 4'd5;
   localparam logic [3:0] REG_T1L_LOW  = 4'd6;
   localparam logic [3:0] REG_T1L_HIGH = 4'd7;
   localparam logic [3:0] REG_T2_LOW   = 4'd8;
   localparam logic [3:0] REG_T2_HIGH  = 4'd9;
   localparam logic [3:0] REG_SR       = 4'd10;
   localparam logic [3:0] REG_ACR      = 4'd11;
   localparam logic [3:0] REG_PCR      = 4'd12;
   localparam logic [3:0] REG_IFR      = 4'd13;
   localparam logic [3:0] REG_IER      = 4'd14;
   localparam logic [3:0] REG_PORTA_NH = 4'd15;

   // interrupt flag bit positions
   localparam int FLAG_CA2 = 0;
   localparam int FLAG_CA1 = 1;
   localparam int FLAG_SR  = 2;
   localparam int FLAG_CB2 = 3;
   localparam int FLAG_CB1 = 4;
   localparam int FLAG_T2  = 5;
   localparam int FLAG_T1  = 6;
   localparam int FLAG_W   = 7;

   // control register bits
   localparam int ACR_T1_FREE_BIT = 6;
   localparam int PCR_CA2_BIT     = 1;
   localparam int IER_SET_BIT     = 7;

   typedef logic [FLAG_W-1:0] flags_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [3:0]  reg_addr;
      logic [7:0]  write_data;
      logic        pin_level;
      logic [15:0] elapsed;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq;
      logic       ca2_out;
   } result_type;

   typedef struct packed {
      logic [15:0] count;
      logic        running;
      logic        underflow;
   } timer_next_type;

endpackage

// ----- design/via_timer.sv -----
// ----------------------------------------------------------------------------
// via_timer
// Count-down step for one timer: subtract elapsed time, stop on underflow.
// ----------------------------------------------------------------------------
module via_timer (
   input  logic [15:0]              count,
   input  logic                     running,
   input  logic [15:0]              elapsed,
   output via_pkg::timer_next_type  nxt
);
   import via_pkg::*;

   logic borrow;

   // underflow only when going below zero; exactly zero keeps running
   assign borrow = count < elapsed;

   always_comb begin
      nxt.count     = count;
      nxt.running   = running;
      nxt.underflow = 1'b0;
      if (running) begin
         if (borrow) begin
            nxt.count     = '0;
            nxt.running   = 1'b0;
            nxt.underflow = 1'b1;
         end else begin
            nxt.count = count - elapsed;
         end
      end
   end

endmodule

// ----- design/via_core.sv -----
// ----------------------------------------------------------------------------
// via_core
// Register file, timers and interrupt logic; applies one transaction per
// cycle while exec_en is high; reads use the old state, irq and ca2 the new.
// ----------------------------------------------------------------------------
`include "versatile_interface_adapter_defines.svh"

module via_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 exec_en,
   input  via_pkg::item_type    item,
   output via_pkg::result_type  result
);
   import via_pkg::*;

   logic [7:0]  port_a_ff, port_a_in;
   logic [7:0]  port_b_ff, port_b_in;
   logic [7:0]  dir_a_ff, dir_a_in;
   logic [7:0]  dir_b_ff, dir_b_in;
   logic [15:0] t1_count_ff, t1_count_in;
   logic [15:0] t1_latch_ff, t1_latch_in;
   logic [15:0] t2_count_ff, t2_count_in;
   logic        t1_run_ff, t1_run_in;
   logic        t2_run_ff, t2_run_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  acr_ff, acr_in;
   logic [7:0]  pcr_ff, pcr_in;
   flags_type   ifr_ff, ifr_in;
   flags_type   ier_ff, ier_in;

   flags_type      flag_clr;
   flags_type      flag_set;
   logic [7:0]     rd;
   logic [7:0]     b;
   timer_next_type t1_nxt;
   timer_next_type t2_nxt;

   assign b = item.write_data;

   // timer count-down steps
   via_timer u_t1 (
      .count   (t1_count_ff),
      .running (t1_run_ff),
      .elapsed (item.elapsed),
      .nxt     (t1_nxt)
   );

   via_timer u_t2 (
      .count   (t2_count_ff),
      .running (t2_run_ff),
      .elapsed (item.elapsed),
      .nxt     (t2_nxt)
   );

   // transaction decode and next state
   always_comb begin
      port_a_in   = port_a_ff;
      port_b_in   = port_b_ff;
      dir_a_in    = dir_a_ff;
      dir_b_in    = dir_b_ff;
      t1_count_in = t1_count_ff;
      t1_latch_in = t1_latch_ff;
      t2_count_in = t2_count_ff;
      t1_run_in   = t1_run_ff;
      t2_run_in   = t2_run_ff;
      shift_in    = shift_ff;
      acr_in      = acr_ff;
      pcr_in      = pcr_ff;
      ier_in      = ier_ff;
      flag_clr    = '0;
      flag_set    = '0;
      rd          = '0;

      if (exec_en) begin
         case (item.func)
            FUNC_READ: begin
               case (item.reg_addr)
                  REG_PORTB: begin
                     rd = port_b_ff;
                     flag_clr[FLAG_CB1] = 1'b1;
                     flag_clr[FLAG_CB2] = 1'b1;
                  end
                  REG_PORTA: begin
                     rd = port_a_ff;
                     flag_clr[FLAG_CA1] = 1'b1;
                     flag_clr[FLAG_CA2] = 1'b1;
                  end
                  REG_DIRB:     rd = dir_b_ff;
                  REG_DIRA:     rd = dir_a_ff;
                  REG_T1_LOW: begin
                     rd = t1_count_ff[7:0];
                     flag_clr[FLAG_T1] = 1'b1;
                  end
                  REG_T1_HIGH:  rd = t1_count_ff[15:8];
                  REG_T1L_LOW:  rd = t1_latch_ff[7:0];
                  REG_T1L_HIGH: rd = t1_latch_ff[15:8];
                  REG_T2_LOW: begin
                     rd = t2_count_ff[7:0];
                     flag_clr[FLAG_T2] = 1'b1;
                  end
                  REG_T2_HIGH:  rd = t2_count_ff[15:8];
                  REG_SR: begin
                     rd = shift_ff;
                     flag_clr[FLAG_SR] = 1'b1;
                  end
                  REG_ACR:      rd = acr_ff;
                  REG_PCR:      rd = pcr_ff;
                  REG_IFR:      rd = {|(ifr_ff & ier_ff), ifr_ff};
                  REG_IER:      rd = {1'b1, ier_ff};
                  REG_PORTA_NH: rd = port_a_ff;
                  default:      rd = '0;
               endcase
            end

            FUNC_WRITE: begin
               case (item.reg_addr)
                  REG_PORTB: begin
                     port_b_in = (b & dir_b_ff) | (port_b_ff & ~dir_b_ff);
                     flag_clr[FLAG_CB1] = 1'b1;
                     flag_clr[FLAG_CB2] = 1'b1;
                  end
                  REG_PORTA: begin
                     port_a_in = (b & dir_a_ff) | (port_a_ff & ~dir_a_ff);
                     flag_clr[FLAG_CA1] = 1'b1;
                     flag_clr[FLAG_CA2] = 1'b1;
                  end
                  REG_DIRB: dir_b_in = b;
                  REG_DIRA: dir_a_in = b;
                  REG_T1_LOW, REG_T1L_LOW: t1_latch_in = {t1_latch_ff[15:8], b};
                  REG_T1_HIGH: begin
                     // latch high byte first, then load the counter from it
                     t1_latch_in = {b, t1_latch_ff[7:0]};
                     t1_count_in = {b, t1_latch_ff[7:0]};
                     t1_run_in   = 1'b1;
                     flag_clr[FLAG_T1] = 1'b1;
                  end
                  REG_T1L_HIGH: begin
                     t1_latch_in = {b, t1_latch_ff[7:0]};
                     flag_clr[FLAG_T1] = 1'b1;
                  end
                  REG_T2_LOW: begin
                     t2_count_in = {8'h00, b};
                     t2_run_in   = 1'b0;
                     flag_clr[FLAG_T2] = 1'b1;
                  end
                  REG_T2_HIGH: begin
                     t2_count_in = t2_count_ff + {b, 8'h00};
                     t2_run_in   = 1'b1;
                     flag_clr[FLAG_T2] = 1'b1;
                  end
                  REG_SR: begin
                     shift_in = b;
                     flag_clr[FLAG_SR] = 1'b1;
                  end
                  REG_ACR: begin
                     acr_in = b;
                     if (b[ACR_T1_FREE_BIT]) begin
                        t1_run_in = 1'b1;
                     end
                  end
                  REG_PCR: pcr_in = b;
                  REG_IFR: flag_clr = b[FLAG_W-1:0];
                  REG_IER: begin
                     if (b[IER_SET_BIT]) begin
                        ier_in = ier_ff | b[FLAG_W-1:0];
                     end else begin
                        ier_in = ier_ff & ~b[FLAG_W-1:0];
                     end
                  end
                  REG_PORTA_NH: port_a_in = (b & dir_a_ff) | (port_a_ff & ~dir_a_ff);
                  default: begin
                  end
               endcase
            end

            FUNC_TICK: begin
               t1_count_in = t1_nxt.count;
               t1_run_in   = t1_nxt.running;
               t2_count_in = t2_nxt.count;
               t2_run_in   = t2_nxt.running;
               flag_set[FLAG_T1] = t1_nxt.underflow;
               flag_set[FLAG_T2] = t2_nxt.underflow;
            end

            FUNC_PIN_A: port_a_in = item.pin_level ? (port_a_ff | b) : (port_a_ff & ~b);
            FUNC_PIN_B: port_b_in = item.pin_level ? (port_b_ff | b) : (port_b_ff & ~b);

            default: begin
            end
         endcase
      end

      // only one of set and clear is active for any transaction
      ifr_in = (ifr_ff & ~flag_clr) | flag_set;
   end

   // read data from the current state, irq and ca2 from the updated state
   assign result.read_data = rd;
   assign result.irq       = |(ifr_in & ier_in);
   assign result.ca2_out   = pcr_in[PCR_CA2_BIT];

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         port_a_ff   <= '0;
         port_b_ff   <= '0;
         dir_a_ff    <= '0;
         dir_b_ff    <= '0;
         t1_count_ff <= '0;
         t1_latch_ff <= '0;
         t2_count_ff <= '0;
         t1_run_ff   <= 1'b0;
         t2_run_ff   <= 1'b0;
         shift_ff    <= '0;
         acr_ff      <= '0;
         pcr_ff      <= '0;
         ifr_ff      <= '0;
         ier_ff      <= '0;
      end else begin
         port_a_ff   <= port_a_in;
         port_b_ff   <= port_b_in;
         dir_a_ff    <= dir_a_in;
         dir_b_ff    <= dir_b_in;
         t1_count_ff <= t1_count_in;
         t1_latch_ff <= t1_latch_in;
         t2_count_ff <= t2_count_in;
         t1_run_ff   <= t1_run_in;
         t2_run_ff   <= t2_run_in;
         shift_ff    <= shift_in;
         acr_ff      <= acr_in;
         pcr_ff      <= pcr_in;
         ifr_ff      <= ifr_in;
         ier_ff      <= ier_in;
      end
   end

   // assertions
   `VIA_ASSERT(a_t1_underflow_stops, clock, reset,
      (exec_en && item.func == FUNC_TICK && t1_nxt.underflow) |=>
      (!t1_run_ff && t1_count_ff == 16'h0000 && ifr_ff[FLAG_T1]), "t1 underflow not applied")
   `VIA_ASSERT(a_t1_low_read_clears, clock, reset,
      (exec_en && item.func == FUNC_READ && item.reg_addr == REG_T1_LOW) |=> !ifr_ff[FLAG_T1],
      "t1 low read did not clear flag")
   `VIA_ASSERT(a_idle_holds_flags, clock, reset,
      !exec_en |=> ($stable(ifr_ff) && $stable(t1_count_ff) && $stable(t2_count_ff)),
      "state changed without a transaction")

endmodule

// ----- design/versatile_interface_adapter.sv -----
// ----------------------------------------------------------------------------
// versatile_interface_adapter
// Sixteen-register 6522-style peripheral: ports, two timers, interrupts.
// ----------------------------------------------------------------------------
// Each transaction (bus read, bus write, time tick or pin change) is captured
// in an input register, applied to the register file and timers once the
// result register is free or draining, and its result lands in an output
// register that drives rsp_valid; one transaction is accepted every cycle
// as long as results are taken. The throughput is set by the single update
// stage, whose longest path is the 16-bit timer subtract and compare.
// ----------------------------------------------------------------------------
`include "versatile_interface_adapter_defines.svh"

module versatile_interface_adapter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [3:0]  req_reg_addr,
   input  logic [7:0]  req_write_data,
   input  logic        req_pin_level,
   input  logic [15:0] req_elapsed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_irq,
   output logic        rsp_ca2_out
);
   import via_pkg::*;

   logic       in_valid_ff;
   item_type   item_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type result;
   logic       exec_fire;
   logic       req_fire;

   // execute when an item waits and the result register is free or draining
   assign exec_fire = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || exec_fire;
   assign req_fire  = req_valid && req_ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.func       <= req_func;
         item_ff.reg_addr   <= req_reg_addr;
         item_ff.write_data <= req_write_data;
         item_ff.pin_level  <= req_pin_level;
         item_ff.elapsed    <= req_elapsed;
      end
   end

   // register file, timers and interrupt logic
   via_core u_core (
      .clock   (clock),
      .reset   (reset),
      .exec_en (exec_fire),
      .item    (item_ff),
      .result  (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_ff.read_data;
   assign rsp_irq       = rsp_ff.irq;
   assign rsp_ca2_out   = rsp_ff.ca2_out;

   // assertions
   `VIA_ASSERT(a_accept_loads_stage, clock, reset,
      req_fire |=> in_valid_ff, "accepted transaction lost at input stage")
   `VIA_ASSERT(a_exec_loads_result, clock, reset,
      exec_fire |=> rsp_valid_ff, "executed transaction produced no result")
   `VIA_ASSERT(a_stall_blocks_input, clock, reset,
      (in_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready,
      "input accepted while both stages full and stalled")

endmodule

// ----- dv/versatile_interface_adapter_tb.sv -----
// ----------------------------------------------------------------------------
// versatile_interface_adapter_tb
// Drives bus reads and writes, time ticks and port pin changes into the
// adapter and compares each result against a cycle-free predictor of the
// register file, the two timers and the interrupt logic, or a typed result.
// A short directed table opens the run, then three phases of biased random
// traffic; both handshake sides stall at random in all but the last phase.
// ----------------------------------------------------------------------------
module versatile_interface_adapter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import via_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 11;
   localparam int ITEMS_PER_PHASE = 450;

   localparam flags_type FL_PORTB = flags_type'((1 << FLAG_CB1) | (1 << FLAG_CB2));
   localparam flags_type FL_PORTA = flags_type'((1 << FLAG_CA1) | (1 << FLAG_CA2));
   localparam flags_type FL_SRBIT = flags_type'(1 << FLAG_SR);
   localparam flags_type FL_TMR1  = flags_type'(1 << FLAG_T1);
   localparam flags_type FL_TMR2  = flags_type'(1 << FLAG_T2);

   localparam logic [2:0] FUNC_SPARE = 3'd7;

   // one row of the directed table: transaction plus optional typed result
   typedef struct packed {
      item_type   it;
      logic       typed;
      result_type want;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_func = '0;
   logic [3:0]  req_reg_addr = '0;
   logic [7:0]  req_write_data = '0;
   logic        req_pin_level = 1'b0;
   logic [15:0] req_elapsed = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        rsp_irq;
   logic        rsp_ca2_out;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches = 0;

   // results still owed by the block, oldest first
   result_type bus_outcomes[$];

   // predicted adapter state
   logic [7:0]  pa_reg, pb_reg, ddra, ddrb, sr_byte, acr, pcr;
   logic [15:0] t1_cnt, t1_lat, t2_cnt;
   logic        t1_on, t2_on;
   flags_type   ifr, ier;

   versatile_interface_adapter u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_reg_addr   (req_reg_addr),
      .req_write_data (req_write_data),
      .req_pin_level  (req_pin_level),
      .req_elapsed    (req_elapsed),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_irq        (rsp_irq),
      .rsp_ca2_out    (rsp_ca2_out)
   );

   always #HALF_PERIOD clock = ~clock;

   // directed table: reset values, timer edges, flag and enable behavior
   directed_row_type directed_table [0:25] = '{
      {FUNC_READ,  REG_IFR,      8'h00, 1'b0, 16'h0000, 1'b1, 8'h00, 1'b0, 1'b0},
      {FUNC_READ,  REG_IER,      8'h00, 1'b0, 16'h0000, 1'b1, 8'h80, 1'b0, 1'b0},
      {FUNC_WRITE, REG_DIRA,     8'hff, 1'b0, 16'h0000, 1'b1, 8'h00, 1'b0, 1'b0},
      {FUNC_WRITE, REG_PORTA,    8'ha5, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0},
      {FUNC_READ,  REG_PORTA,    8'h00, 1'b0, 16'h0000, 1'b1, 8'ha5, 1'b0, 1'b0},
      {FUNC_PIN_A, REG_PORTB,    8'h0f, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0},
      {FUNC_READ,  REG_PORTA_NH, 8'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0},
      {FUNC_PIN_B, REG_PORTA,    8'hff, 1'b1, 16'hffff, 1'b0, 8'h00, 1'b0, 1'b0},
      {FUNC_READ,  REG_PORTB,    8'h00, 1'b0, 16'h0000, 1'b1, 8'hff, 1'b0, 1'b0},
      {FUNC_WRITE, REG_IER,      8'hff, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0},
      {FUNC_WRITE, REG_T1L_LOW,  8'h02, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0},
      {FUNC_WRITE, REG_T1_HIGH,  8'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0},
      {FUNC_TICK,  REG_PORTB,    8'h00, 1'b0, 16'h0002, 1'b0, 8'h00, 1'b0, 1'b0},
      {FUNC_TICK,  REG_PORTB,    8'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0},
      {FUNC_READ,  REG_T1_LOW,   8'h00, 1'b0, 16'h0000, 1'b1, 8'h00, 1'b0, 1'b0},
      {FUNC_TICK,  REG_PORTB,    8'h00, 1'b0, 16'h0001, 1'b0, 8'h00, 1'b0, 1'b0},
      {FUNC_READ,  REG_IFR,      8'h00, 1'b0, 16'h0000, 1'b1, 8'hc0, 1'b1, 1'b0},
      {FUNC_WRITE, REG_IFR,      8'h7f, 1'b0, 16'h0000, 1'b1, 8'h00, 1'b0, 1'b0},
      {FUNC_WRITE, REG_IER,      8'h7f, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0},
      {FUNC_WRITE, REG_T2_LOW,   8'hff, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0},
      {FUNC_WRITE, REG_T2_HIGH,  8'hff, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0},
      {FUNC_TICK,  REG_IER,      8'hff, 1'b1, 16'hffff, 1'b0, 8'h00, 1'b0, 1'b0},
      {FUNC_TICK,  REG_IER,      8'hff, 1'b1, 16'hffff, 1'b0, 8'h00, 1'b0, 1'b0},
      {FUNC_WRITE, REG_IER,      8'ha0, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0},
      {FUNC_WRITE, REG_PCR,      8'h02, 1'b0, 16'h0000, 1'b1, 8'h00, 1'b1, 1'b1},
      {FUNC_SPARE, REG_PORTA_NH, 8'hff, 1'b1, 16'hffff, 1'b1, 8'h00, 1'b1, 1'b1}
   };

   function automatic void drop_flags(flags_type m);
      ifr = ifr & ~m;
   endfunction

   // running timer counts down; going below zero stops it and raises its flag
   task automatic count_down(inout logic [15:0] cnt, inout logic on,
                             input logic [15:0] el, input flags_type flag);
      if (on) begin
         if (cnt < el) begin
            cnt = '0;
            on  = 1'b0;
            ifr = ifr | flag;
         end else begin
            cnt = cnt - el;
         end
      end
   endtask

   function automatic logic [7:0] bus_read_byte(logic [3:0] ra);
      logic [7:0] rd;
      rd = '0;
      case (ra)
         REG_PORTB:    begin rd = pb_reg; drop_flags(FL_PORTB); end
         REG_PORTA:    begin rd = pa_reg; drop_flags(FL_PORTA); end
         REG_DIRB:     rd = ddrb;
         REG_DIRA:     rd = ddra;
         REG_T1_LOW:   begin rd = t1_cnt[7:0]; drop_flags(FL_TMR1); end
         REG_T1_HIGH:  rd = t1_cnt[15:8];
         REG_T1L_LOW:  rd = t1_lat[7:0];
         REG_T1L_HIGH: rd = t1_lat[15:8];
         REG_T2_LOW:   begin rd = t2_cnt[7:0]; drop_flags(FL_TMR2); end
         REG_T2_HIGH:  rd = t2_cnt[15:8];
         REG_SR:       begin rd = sr_byte; drop_flags(FL_SRBIT); end
         REG_ACR:      rd = acr;
         REG_PCR:      rd = pcr;
         REG_IFR:      rd = {|(ifr & ier), ifr};
         REG_IER:      rd = {1'b1, ier};
         default:      rd = pa_reg;
      endcase
      return rd;
   endfunction

   function automatic void bus_write_byte(logic [3:0] ra, logic [7:0] b);
      case (ra)
         REG_PORTB: begin
            pb_reg = (b & ddrb) | (pb_reg & ~ddrb);
            drop_flags(FL_PORTB);
         end
         REG_PORTA: begin
            pa_reg = (b & ddra) | (pa_reg & ~ddra);
            drop_flags(FL_PORTA);
         end
         REG_DIRB:    ddrb = b;
         REG_DIRA:    ddra = b;
         REG_T1_LOW, REG_T1L_LOW: t1_lat[7:0] = b;
         REG_T1_HIGH: begin
            t1_lat[15:8] = b;
            t1_cnt = t1_lat;
            t1_on  = 1'b1;
            drop_flags(FL_TMR1);
         end
         REG_T1L_HIGH: begin
            t1_lat[15:8] = b;
            drop_flags(FL_TMR1);
         end
         REG_T2_LOW: begin
            t2_cnt = {8'h00, b};
            t2_on  = 1'b0;
            drop_flags(FL_TMR2);
         end
         REG_T2_HIGH: begin
            t2_cnt = t2_cnt + {b, 8'h00};
            t2_on  = 1'b1;
            drop_flags(FL_TMR2);
         end
         REG_SR: begin
            sr_byte = b;
            drop_flags(FL_SRBIT);
         end
         REG_ACR: begin
            acr = b;
            if (b[ACR_T1_FREE_BIT]) t1_on = 1'b1;
         end
         REG_PCR: pcr = b;
         REG_IFR: drop_flags(b[6:0]);
         REG_IER: begin
            if (b[IER_SET_BIT]) ier = ier | b[6:0];
            else ier = ier & ~b[6:0];
         end
         default: pa_reg = (b & ddra) | (pa_reg & ~ddra);
      endcase
   endfunction

   // applies one transaction to the predicted state, returns its result
   task automatic via_access(input item_type it, output result_type res);
      logic [7:0] rd;
      rd = '0;
      case (it.func)
         FUNC_READ:  rd = bus_read_byte(it.reg_addr);
         FUNC_WRITE: bus_write_byte(it.reg_addr, it.write_data);
         FUNC_TICK: begin
            count_down(t1_cnt, t1_on, it.elapsed, FL_TMR1);
            count_down(t2_cnt, t2_on, it.elapsed, FL_TMR2);
         end
         FUNC_PIN_A: pa_reg = it.pin_level ? (pa_reg | it.write_data)
                                           : (pa_reg & ~it.write_data);
         FUNC_PIN_B: pb_reg = it.pin_level ? (pb_reg | it.write_data)
                                           : (pb_reg & ~it.write_data);
         default: ;
      endcase
      res.read_data = rd;
      res.irq       = |(ifr & ier);
      res.ca2_out   = pcr[PCR_CA2_BIT];
   endtask

   // presents one transaction, holds it until accepted, records its result
   task automatic send_item(input item_type it, input logic typed,
                            input result_type want);
      result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= it.func;
      req_reg_addr   <= it.reg_addr;
      req_write_data <= it.write_data;
      req_pin_level  <= it.pin_level;
      req_elapsed    <= it.elapsed;
      do @(posedge clock); while (!req_ready);
      via_access(it, predicted);
      bus_outcomes.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   // random transaction, biased so timers get armed and run out often
   function automatic item_type random_item();
      item_type it;
      int pick;
      it.func       = FUNC_READ;
      it.reg_addr   = 4'($urandom_range(15));
      it.write_data = 8'($urandom_range(255));
      it.pin_level  = 1'($urandom_range(1));
      it.elapsed    = 16'($urandom_range(65535));
      pick = $urandom_range(99);
      if (pick < 28) begin
         it.func = FUNC_READ;
      end else if (pick < 63) begin
         it.func = FUNC_WRITE;
         if ($urandom_range(99) < 40)
            it.reg_addr = 4'($urandom_range(REG_T2_HIGH, REG_T1_LOW));
         if ((it.reg_addr == REG_T1_HIGH || it.reg_addr == REG_T1L_HIGH ||
              it.reg_addr == REG_T2_HIGH) && $urandom_range(99) < 75)
            it.write_data = 8'($urandom_range(2));
      end else if (pick < 85) begin
         it.func = FUNC_TICK;
         if ($urandom_range(99) < 85) it.elapsed = 16'($urandom_range(300));
      end else if (pick < 92) begin
         it.func = FUNC_PIN_A;
      end else if (pick < 97) begin
         it.func = FUNC_PIN_B;
      end else begin
         it.func = 3'($urandom_range(7, 5));
      end
      return it;
   endfunction

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      result_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (bus_outcomes.size() == 0) begin
            $error("result transaction with nothing expected");
            mismatches++;
         end else begin
            exp_res = bus_outcomes.pop_front();
            if (rsp_read_data !== exp_res.read_data) begin
               $error("read_data: expected %02h, got %02h",
                      exp_res.read_data, rsp_read_data);
               mismatches++;
            end
            if (rsp_irq !== exp_res.irq) begin
               $error("irq: expected %0b, got %0b", exp_res.irq, rsp_irq);
               mismatches++;
            end
            if (rsp_ca2_out !== exp_res.ca2_out) begin
               $error("ca2_out: expected %0b, got %0b", exp_res.ca2_out, rsp_ca2_out);
               mismatches++;
            end
         end
      end
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   // main sequence
   initial begin
      result_type none;
      int counted;
      item_type it;
      none = '0;
      pa_reg = '0; pb_reg = '0; ddra = '0; ddrb = '0;
      sr_byte = '0; acr = '0; pcr = '0;
      t1_cnt = '0; t1_lat = '0; t2_cnt = '0;
      t1_on = 1'b0; t2_on = 1'b0;
      ifr = '0; ier = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 31;
      recv_idle_pct = 60;
      for (int i = 0; i < $size(directed_table); i++)
         send_item(directed_table[i].it, directed_table[i].typed, directed_table[i].want);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 31; recv_idle_pct = 60; end
            1: begin send_idle_pct = 60; recv_idle_pct = 31; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            it = random_item();
            send_item(it, 1'b0, none);
            if (it.func <= FUNC_PIN_B) counted++;
         end
         // hold off until the block has drained
         req_valid <= 1'b0;
         while (bus_outcomes.size() != 0) @(negedge clock);
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0 && bus_outcomes.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
